@@ rtl/charger_mode_controller_defines.svh @@
// Assertion macros for the charger mode controller.
// The clocked forms sample on clk; the guarded form ignores cycles in reset.
`ifndef CHARGER_MODE_CONTROLLER_DEFINES_SVH
`define CHARGER_MODE_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

`define CMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define CMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CMC_ASSERT(lbl, prop, msg)

`define CMC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/cmc_pkg.sv @@
package cmc_pkg;

  localparam int CMC_DELAY_WIDTH = 16;
  localparam int CMC_THR_WIDTH   = 16;
  localparam logic [CMC_THR_WIDTH-1:0] CMC_DELAY_RESET = 16'd100;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_AUTO   = 2'd2,
    MODE_FAULT  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OUT_IDLE    = 3'd0,
    OUT_MANUAL  = 3'd1,
    OUT_STANDBY = 3'd2,
    OUT_AUTO    = 3'd3,
    OUT_FAULT   = 3'd4
  } omode_t;

  typedef enum logic [1:0] {
    REQ_STANDBY = 2'd0,
    REQ_MANUAL  = 2'd1,
    REQ_AUTO    = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    TMR_HOLD  = 2'd0,
    TMR_START = 2'd1,
    TMR_STOP  = 2'd2
  } tmr_op_t;

  typedef enum logic {
    CFG_START_DELAY = 1'b0,
    CFG_FLOAT_DELAY = 1'b1
  } cfg_idx_t;

  // Mode pair produced by the transition logic.
  typedef struct packed {
    mode_t  mode;
    omode_t omode;
  } mode_upd_t;

endpackage

@@ rtl/cmc_mode.sv @@
module cmc_mode
  import cmc_pkg::*;
(
  input  mode_t     mode_cur,
  input  logic      abnormal,
  input  logic      ready,
  input  req_t      req,
  output mode_upd_t upd
);

  // Fault wins over everything, then loss of readiness drops to idle.
  always_comb begin
    upd.mode  = MODE_IDLE;
    upd.omode = OUT_IDLE;
    priority if (mode_cur == MODE_FAULT) begin
      if (abnormal) begin
        upd.mode  = MODE_FAULT;
        upd.omode = OUT_FAULT;
      end
    end else if (abnormal) begin
      upd.mode  = MODE_FAULT;
      upd.omode = OUT_FAULT;
    end else if (!ready) begin
      upd.mode  = MODE_IDLE;
      upd.omode = OUT_IDLE;
    end else if (mode_cur == MODE_IDLE) begin
      if (req == REQ_AUTO) begin
        upd.mode  = MODE_AUTO;
        upd.omode = OUT_AUTO;
      end else if (req == REQ_MANUAL) begin
        upd.mode  = MODE_MANUAL;
        upd.omode = OUT_MANUAL;
      end
    end else if (mode_cur == MODE_MANUAL) begin
      if (req == REQ_AUTO) begin
        upd.mode  = MODE_AUTO;
        upd.omode = OUT_AUTO;
      end else if (req == REQ_STANDBY) begin
        upd.mode  = MODE_MANUAL;
        upd.omode = OUT_STANDBY;
      end else begin
        upd.mode  = MODE_MANUAL;
        upd.omode = OUT_MANUAL;
      end
    end else begin
      if (req == REQ_MANUAL) begin
        upd.mode  = MODE_MANUAL;
        upd.omode = OUT_MANUAL;
      end else begin
        upd.mode  = MODE_AUTO;
        upd.omode = OUT_AUTO;
      end
    end
  end

endmodule

@@ rtl/cmc_timer.sv @@
module cmc_timer
  import cmc_pkg::*;
#(
  parameter int DELAY_WIDTH = CMC_DELAY_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  tmr_op_t                  op,
  input  logic [CMC_THR_WIDTH-1:0] threshold,
  output logic                     expired,
  output logic                     running
);

  localparam int CW = (DELAY_WIDTH > CMC_THR_WIDTH) ? DELAY_WIDTH : CMC_THR_WIDTH;
  localparam logic [DELAY_WIDTH-1:0] CNT_MAX = {DELAY_WIDTH{1'b1}};

  logic                   running_r, running_nxt;
  logic [DELAY_WIDTH-1:0] count_r, count_nxt;
  logic [DELAY_WIDTH-1:0] start_cnt;

  // Count that a start on this tick produces: zero from stopped, otherwise
  // one more, held at the top of the range.
  always_comb begin
    start_cnt = '0;
    if (running_r) begin
      start_cnt = (count_r != CNT_MAX) ? count_r + 1'b1 : count_r;
    end
  end

  always_comb begin
    running_nxt = running_r;
    count_nxt   = count_r;
    unique case (op)
      TMR_START: begin
        running_nxt = 1'b1;
        count_nxt   = start_cnt;
      end
      TMR_STOP: begin
        running_nxt = 1'b0;
        count_nxt   = '0;
      end
      default: begin
        running_nxt = running_r;
        count_nxt   = count_r;
      end
    endcase
  end

  // The expiry flag does not depend on the operation, so the caller can
  // pick the operation from it. A threshold beyond the counter range simply
  // never compares true.
  assign expired = (CW'(start_cnt) >= CW'(threshold));
  assign running = running_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      count_r   <= '0;
    end else if (en) begin
      running_r <= running_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

@@ rtl/charger_mode_controller.sv @@
// Charger mode controller.
// Input channel in_*: one item per controller tick carrying the fault,
// readiness, enable, mode request and charger feedback flags. Result channel
// out_*: exactly one item per input item with the new mode, the output mode,
// the charge command, a send-request pulse and the charge-complete flag.
// Configuration port cfg_*: index 0 sets the start delay and index 1 the
// float delay, both in ticks; write them only while no item is in flight.
// An accepted item lands in an input register; from there the mode
// transition, the action for the new output mode and both delay timers are
// evaluated in one pass and the result lands in the output register as soon
// as that register is free. With a ready receiver, one item per cycle is
// sustained. When the receiver stalls, the result stays in the output
// register and the input register still takes one further item; after that
// in_tready drops until the result is taken. Reset clears the valid flags of
// both pipeline registers, returns the controller to idle with the command
// off, stops both timers and loads both delays with 100 ticks.
`include "charger_mode_controller_defines.svh"

module charger_mode_controller
  import cmc_pkg::*;
#(
  parameter int DELAY_WIDTH = CMC_DELAY_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input channel.
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // [0] abnormal, [1] conditions_ok, [2] charge_enable, [4:3] mode_request,
  // [5] charging, [6] in_station, [7] float_phase
  input  logic [7:0]               in_tdata,
  // Result channel.
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // [1:0] mode_state, [4:2] output_mode, [5] charge_command,
  // [6] send_request, [7] charge_complete
  output logic [7:0]               out_tdata,
  // Configuration write port.
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CMC_THR_WIDTH-1:0] cfg_data
);

  // Input register.
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_data_r;

  // Result register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;

  // Controller state and configuration.
  mode_t                    mode_r;
  omode_t                   omode_r;
  logic                     cmd_r, cmd_nxt;
  logic                     cmplt_r, cmplt_nxt;
  logic [CMC_THR_WIDTH-1:0] start_thr_r;
  logic [CMC_THR_WIDTH-1:0] float_thr_r;

  logic       in_accept;
  logic       out_load;
  logic       abnormal, ready, chg, stn, flt;
  req_t       req;
  mode_upd_t  upd;
  logic       send;
  tmr_op_t    start_op, float_op;
  logic       start_exp, float_exp;
  logic       start_run, float_run;

  // The result register frees up when empty or when its item is taken.
  assign out_load  = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || out_load;
  assign in_accept = in_tvalid && in_tready;

  assign in_valid_nxt  = in_accept ? 1'b1 : (out_load ? 1'b0 : in_valid_r);
  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // Unpack the held item.
  assign abnormal = in_data_r[0];
  assign ready    = in_data_r[1] && in_data_r[2];
  assign req      = req_t'(in_data_r[4:3]);
  assign chg      = in_data_r[5];
  assign stn      = in_data_r[6];
  assign flt      = in_data_r[7];

  cmc_mode u_mode (
    .mode_cur (mode_r),
    .abnormal (abnormal),
    .ready    (ready),
    .req      (req),
    .upd      (upd)
  );

  // Action for the new output mode. The timers only advance on a processed
  // item, and their expiry flags reflect the count a start on this tick gives.
  always_comb begin
    cmd_nxt   = cmd_r;
    cmplt_nxt = cmplt_r;
    send      = 1'b0;
    start_op  = TMR_HOLD;
    float_op  = TMR_HOLD;
    unique case (upd.omode)
      OUT_MANUAL: begin
        cmd_nxt = 1'b1;
        if (!chg) begin
          send = 1'b1;
        end else begin
          start_op = TMR_STOP;
          float_op = TMR_STOP;
        end
      end
      OUT_STANDBY: begin
        send     = chg;
        cmd_nxt  = 1'b0;
        start_op = TMR_STOP;
        float_op = TMR_STOP;
      end
      OUT_AUTO: begin
        if (stn) begin
          if (!chg && !cmplt_r) begin
            start_op = TMR_START;
            if (start_exp) begin
              cmd_nxt = 1'b1;
              send    = 1'b1;
            end
          end else if (flt) begin
            float_op = TMR_START;
            if (float_exp) begin
              cmd_nxt   = 1'b0;
              cmplt_nxt = 1'b1;
              send      = 1'b1;
            end
          end
        end else begin
          send      = chg;
          cmd_nxt   = 1'b0;
          cmplt_nxt = 1'b0;
          start_op  = TMR_STOP;
          float_op  = TMR_STOP;
        end
      end
      default: begin
        // Idle and fault: only a charging charger is told to stop.
        if (chg) begin
          cmd_nxt = 1'b0;
          send    = 1'b1;
        end
        start_op = TMR_STOP;
        float_op = TMR_STOP;
      end
    endcase
  end

  cmc_timer #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_start_tmr (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (out_load),
    .op        (start_op),
    .threshold (start_thr_r),
    .expired   (start_exp),
    .running   (start_run)
  );

  cmc_timer #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_float_tmr (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (out_load),
    .op        (float_op),
    .threshold (float_thr_r),
    .expired   (float_exp),
    .running   (float_run)
  );

  assign out_data_nxt = {cmplt_nxt, send, cmd_nxt, upd.omode, upd.mode};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_IDLE;
      omode_r     <= OUT_IDLE;
      cmd_r       <= 1'b0;
      cmplt_r     <= 1'b0;
      start_thr_r <= CMC_DELAY_RESET;
      float_thr_r <= CMC_DELAY_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (out_load) begin
        mode_r  <= upd.mode;
        omode_r <= upd.omode;
        cmd_r   <= cmd_nxt;
        cmplt_r <= cmplt_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_START_DELAY: start_thr_r <= cfg_data;
          CFG_FLOAT_DELAY: float_thr_r <= cfg_data;
          default: start_thr_r <= start_thr_r;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_data_r <= in_tdata;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The fault mode and the fault output mode always travel together.
  `CMC_ASSERT(a_fault_pair, (mode_r == MODE_FAULT) == (omode_r == OUT_FAULT), "fault mode and fault output mode disagree")

  // Manual standby is only ever an output view of manual mode.
  `CMC_ASSERT(a_standby_manual, (omode_r == OUT_STANDBY) |-> (mode_r == MODE_MANUAL), "standby output outside manual mode")

  // A delay timer can only be left running by auto or by manual.
  `CMC_ASSERT(a_timer_mode, (start_run || float_run) |-> (omode_r == OUT_AUTO || omode_r == OUT_MANUAL), "delay timer running in a mode that stops it")

endmodule
